// ===== rtl/core/i2p_pkg.sv =====
// Shared constants, types and helper functions of the infix-to-postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

  // Field widths and default stack depth.
  localparam int CHAR_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int STACK_DEPTH  = 16;

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;

  // Status codes carried by each result.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  // One result before the per-item flags are attached.
  typedef struct packed {
    logic [CHAR_W-1:0]   out_char;
    logic                has_char;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Precedence, shifted up by one so that "other" is the lowest code.
  function automatic logic [1:0] prec(input logic [CHAR_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  // True for ASCII letters of either case.
  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

endpackage

// ===== rtl/core/i2p_if.sv =====
// Valid/ready channel interfaces for the converter's input and result streams.
`timescale 1ns / 1ps

interface i2p_in_if;
  logic                       valid;
  logic                       ready;
  logic [i2p_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface i2p_out_if;
  logic                         valid;
  logic                         ready;
  logic [i2p_pkg::CHAR_W-1:0]   out_char;
  logic                         has_char;
  logic [i2p_pkg::STATUS_W-1:0] status;
  logic                         run_last;
  logic                         expr_end;

  modport source (output valid, output out_char, output has_char, output status,
                  output run_last, output expr_end, input ready);
  modport sink (input valid, input out_char, input has_char, input status,
                input run_last, input expr_end, output ready);
endinterface

// ===== rtl/core/i2p_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/infix_to_postfix_converter_unit.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
`timescale 1ns / 1ps

// The converter takes one character per input transaction, with in_last on the final
// character of an expression, and sends the expression out in postfix order, one result
// transaction per emitted character or status marker. It works on one character at a
// time: a new input transaction is taken only once the previous character is done. A
// letter goes straight out and an opening parenthesis is pushed. A closing parenthesis
// pops operators down to its opening parenthesis, and an operator pops those of equal
// or higher precedence before it is pushed. On the last character the flush pops every
// entry left on the stack. Characters after an unmatched closing parenthesis are
// ignored. The operator stack RAM has one registered read port and gives up one entry
// per cycle during a pop run while the result side does not stall; stalls on the result
// side hold the converter. Results leave through an output register; the final result
// of each item carries run_last, and the final result of an expression also carries
// expr_end.

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH
) (
  input logic        clk,
  input logic        rst,
  i2p_in_if.sink     in_chan,
  i2p_out_if.source  out_chan
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_PUSH, S_FLUSH_START, S_POP, S_RP_FAIL, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_RPAREN, M_OPER, M_FLUSH
  } mode_t;

  state_t                     state, state_next;
  mode_t                      mode, mode_next;
  logic [CW-1:0]              count, count_next;
  logic                       failed, failed_next;
  logic [i2p_pkg::CHAR_W-1:0] cur_char, cur_char_next;
  logic                       cur_last, cur_last_next;
  logic                       pend_v, pend_v_next;
  i2p_pkg::res_t              pend, pend_next;
  logic                       out_v, out_v_next;
  i2p_pkg::res_t              out_res, out_res_next;
  logic                       out_run, out_run_next;
  logic                       out_end, out_end_next;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [i2p_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

  logic                       gen_fire;
  i2p_pkg::res_t              gen_res;
  logic                       slot_free, gen_ok, take, done_go;
  logic [CW-1:0]              cnt_m1, cnt_m2;

  // Operator stack storage.
  i2p_ram #(
    .WIDTH(i2p_pkg::CHAR_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign slot_free = !out_v || out_chan.ready;
  // A new result can be produced once the held one has somewhere to go.
  assign gen_ok    = !pend_v || slot_free;

  assign in_chan.ready     = (state == S_IDLE);
  assign out_chan.valid    = out_v;
  assign out_chan.out_char = out_res.out_char;
  assign out_chan.has_char = out_res.has_char;
  assign out_chan.status   = out_res.status;
  assign out_chan.run_last = out_run;
  assign out_chan.expr_end = out_end;

  // Sequencer: one result is held back so the final one of an item can be flagged.
  always_comb begin
    state_next    = state;
    mode_next     = mode;
    count_next    = count;
    failed_next   = failed;
    cur_char_next = cur_char;
    cur_last_next = cur_last;
    pend_v_next   = pend_v;
    pend_next     = pend;
    out_v_next    = out_v && !out_chan.ready;
    out_res_next  = out_res;
    out_run_next  = out_run;
    out_end_next  = out_end;
    ram_we        = 1'b0;
    ram_waddr     = count[AW-1:0];
    ram_wdata     = cur_char;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[AW-1:0];
    gen_fire      = 1'b0;
    gen_res       = '0;
    take          = 1'b0;
    done_go       = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_chan.valid) begin
          cur_char_next = in_chan.in_char;
          cur_last_next = in_chan.in_last;
          state_next    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (failed) begin
          if (!cur_last) begin
            state_next = S_IDLE;
          end else if (gen_ok) begin
            gen_fire        = 1'b1;
            gen_res.status  = i2p_pkg::ST_UNMATCHED;
            state_next      = S_DONE;
          end
        end else if (i2p_pkg::is_letter(cur_char)) begin
          if (gen_ok) begin
            gen_fire         = 1'b1;
            gen_res.out_char = cur_char;
            gen_res.has_char = 1'b1;
            state_next       = cur_last ? S_FLUSH_START : S_DONE;
          end
        end else if (cur_char == i2p_pkg::CH_LPAREN) begin
          state_next = S_PUSH;
        end else begin
          mode_next = (cur_char == i2p_pkg::CH_RPAREN) ? M_RPAREN : M_OPER;
          if (count != '0) begin
            ram_re     = 1'b1;
            state_next = S_POP;
          end else begin
            state_next = (cur_char == i2p_pkg::CH_RPAREN) ? S_RP_FAIL : S_PUSH;
          end
        end
      end

      S_PUSH: begin
        if (count == CW'(STACK_DEPTH)) begin
          if (gen_ok) begin
            gen_fire       = 1'b1;
            gen_res.status = i2p_pkg::ST_OVERFLOW;
            state_next     = cur_last ? S_FLUSH_START : S_DONE;
          end
        end else begin
          ram_we     = 1'b1;
          count_next = count + CW'(1);
          state_next = cur_last ? S_FLUSH_START : S_DONE;
        end
      end

      S_FLUSH_START: begin
        mode_next = M_FLUSH;
        if (count != '0) begin
          ram_re     = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = S_DONE;
        end
      end

      S_POP: begin
        case (mode)
          M_RPAREN: take = (ram_rdata != i2p_pkg::CH_LPAREN);
          M_OPER:   take = (i2p_pkg::prec(cur_char) <= i2p_pkg::prec(ram_rdata));
          default:  take = 1'b1;
        endcase
        if (take) begin
          if (gen_ok) begin
            gen_fire         = 1'b1;
            gen_res.out_char = ram_rdata;
            gen_res.has_char = 1'b1;
            count_next       = cnt_m1;
            if (count > CW'(1)) begin
              // Fetch the entry below while this one goes out.
              ram_re    = 1'b1;
              ram_raddr = cnt_m2[AW-1:0];
            end else begin
              case (mode)
                M_RPAREN: state_next = S_RP_FAIL;
                M_OPER:   state_next = S_PUSH;
                default:  state_next = S_DONE;
              endcase
            end
          end
        end else begin
          case (mode)
            M_RPAREN: begin
              // Matching opening parenthesis is dropped.
              count_next = cnt_m1;
              state_next = cur_last ? S_FLUSH_START : S_DONE;
            end
            M_OPER:  state_next = S_PUSH;
            default: state_next = S_DONE;
          endcase
        end
      end

      S_RP_FAIL: begin
        if (gen_ok) begin
          gen_fire       = 1'b1;
          gen_res.status = i2p_pkg::ST_UNMATCHED;
          failed_next    = 1'b1;
          state_next     = S_DONE;
        end
      end

      S_DONE: begin
        if (pend_v) begin
          if (slot_free) begin
            out_v_next   = 1'b1;
            out_res_next = pend;
            out_run_next = 1'b1;
            out_end_next = cur_last;
            pend_v_next  = 1'b0;
            done_go      = 1'b1;
          end
        end else if (cur_last) begin
          if (slot_free) begin
            out_v_next   = 1'b1;
            out_res_next = '0;
            out_run_next = 1'b1;
            out_end_next = 1'b1;
            done_go      = 1'b1;
          end
        end else begin
          done_go = 1'b1;
        end
        if (done_go) begin
          state_next = S_IDLE;
          if (cur_last) begin
            count_next  = '0;
            failed_next = 1'b0;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase

    // A new result pushes the held one out as a non-final result.
    if (gen_fire) begin
      if (pend_v) begin
        out_v_next   = 1'b1;
        out_res_next = pend;
        out_run_next = 1'b0;
        out_end_next = 1'b0;
      end
      pend_next   = gen_res;
      pend_v_next = 1'b1;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mode   <= M_FLUSH;
      count  <= '0;
      failed <= 1'b0;
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      state  <= state_next;
      mode   <= mode_next;
      count  <= count_next;
      failed <= failed_next;
      pend_v <= pend_v_next;
      out_v  <= out_v_next;
    end
    cur_char <= cur_char_next;
    cur_last <= cur_last_next;
    pend     <= pend_next;
    out_res  <= out_res_next;
    out_run  <= out_run_next;
    out_end  <= out_end_next;
  end

endmodule

// ===== rtl/core/i2p_checker.sv =====
// Port-level assertions for the converter, bound to its top level.
`timescale 1ns / 1ps

module i2p_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [i2p_pkg::CHAR_W-1:0]   out_char,
  input logic                         out_has_char,
  input logic [i2p_pkg::STATUS_W-1:0] out_status,
  input logic                         out_run_last,
  input logic                         out_expr_end
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_has_char)
      && $stable(out_status) && $stable(out_run_last) && $stable(out_expr_end))
    else $error("result payload changed while stalled");

  // The end of an expression is always also the end of an item.
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_expr_end |-> out_run_last)
    else $error("expr_end without run_last");

  // A character result always carries an ok status.
  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_has_char |-> out_status == i2p_pkg::ST_OK)
    else $error("character result with error status");

  // After an input transaction the converter is not ready again in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_char    (out_chan.out_char),
  .out_has_char(out_chan.has_char),
  .out_status  (out_chan.status),
  .out_run_last(out_chan.run_last),
  .out_expr_end(out_chan.expr_end)
);

// ===== tb/sv/i2p_postfix_checker.sv =====
// Checker for the infix-to-postfix converter: predicts postfix results and compares them.
`timescale 1ns / 1ps

module i2p_postfix_checker (
  input  logic clk,
  input  logic rst,
  i2p_in_if    in_mon,
  i2p_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import i2p_pkg::*;

  localparam int DEPTH      = i2p_pkg::STACK_DEPTH;
  localparam int PRINT_CAP  = 50;

  // One postfix result with its per-item and per-expression flags.
  typedef struct packed {
    logic [CHAR_W-1:0]   out_char;
    logic                has_char;
    logic [STATUS_W-1:0] status;
    logic                run_last;
    logic                expr_end;
  } postfix_res_t;

  // Shadow copy of the converter's operator stack and error flag.
  logic [CHAR_W-1:0] op_mem [DEPTH];
  int unsigned       op_cnt;
  logic              unmatched_seen;

  // Postfix results still to arrive, oldest first, and those of the current character.
  postfix_res_t awaited_postfix[$];
  postfix_res_t step_postfix[$];

  initial fail_count = 0;

  // Operator precedence: higher binds tighter, anything unknown is lowest.
  function automatic int op_rank(input logic [CHAR_W-1:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    if (c == CH_STAR || c == CH_SLASH) return 2;
    if (c == CH_CARET) return 3;
    return -1;
  endfunction

  function automatic bit alpha_char(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic void emit_postfix(input logic [CHAR_W-1:0] c, input logic has,
                                       input logic [STATUS_W-1:0] st);
    postfix_res_t r;
    r.out_char = c;
    r.has_char = has;
    r.status   = st;
    r.run_last = 1'b0;
    r.expr_end = 1'b0;
    step_postfix.push_back(r);
  endfunction

  function automatic logic [CHAR_W-1:0] pop_operator();
    op_cnt--;
    return op_mem[op_cnt];
  endfunction

  // A push onto a full stack is dropped and flagged with an overflow marker.
  function automatic void push_operator(input logic [CHAR_W-1:0] c);
    if (op_cnt >= DEPTH) begin
      emit_postfix('0, 1'b0, ST_OVERFLOW);
    end else begin
      op_mem[op_cnt] = c;
      op_cnt++;
    end
  endfunction

  // Shunting-yard step for one accepted character.
  function automatic void convert_char(input logic [CHAR_W-1:0] c, input logic last);
    int p;
    step_postfix.delete();
    if (unmatched_seen) begin
      // Input is dropped until the end of the expression.
      if (last) emit_postfix('0, 1'b0, ST_UNMATCHED);
    end else begin
      if (alpha_char(c)) begin
        emit_postfix(c, 1'b1, ST_OK);
      end else if (c == CH_LPAREN) begin
        push_operator(c);
      end else if (c == CH_RPAREN) begin
        while (op_cnt > 0 && op_mem[op_cnt-1] != CH_LPAREN)
          emit_postfix(pop_operator(), 1'b1, ST_OK);
        if (op_cnt > 0) begin
          op_cnt--;
        end else begin
          emit_postfix('0, 1'b0, ST_UNMATCHED);
          unmatched_seen = 1'b1;
        end
      end else begin
        p = op_rank(c);
        while (op_cnt > 0 && p <= op_rank(op_mem[op_cnt-1]))
          emit_postfix(pop_operator(), 1'b1, ST_OK);
        push_operator(c);
      end
      // Flush whatever is left at the end of the expression.
      if (last && !unmatched_seen) begin
        while (op_cnt > 0) emit_postfix(pop_operator(), 1'b1, ST_OK);
      end
      if (last && step_postfix.size() == 0) emit_postfix('0, 1'b0, ST_OK);
    end
    if (step_postfix.size() > 0) begin
      step_postfix[step_postfix.size()-1].run_last = 1'b1;
      if (last) step_postfix[step_postfix.size()-1].expr_end = 1'b1;
    end
    foreach (step_postfix[i]) awaited_postfix.push_back(step_postfix[i]);
    if (last) begin
      op_cnt         = 0;
      unmatched_seen = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Predict on each input transaction, then check each result transaction.
  always @(posedge clk) begin
    postfix_res_t want;
    if (rst) begin
      op_cnt         = 0;
      unmatched_seen = 1'b0;
      awaited_postfix.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) convert_char(in_mon.in_char, in_mon.in_last);
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_postfix.size() == 0) begin
          report_mismatch($sformatf("unexpected result char %02h has %0d status %0d",
                                    out_mon.out_char, out_mon.has_char, out_mon.status));
        end else begin
          want = awaited_postfix.pop_front();
          if (out_mon.out_char !== want.out_char)
            report_mismatch($sformatf("out_char %02h, predicted %02h",
                                      out_mon.out_char, want.out_char));
          if (out_mon.has_char !== want.has_char)
            report_mismatch($sformatf("has_char %0d, predicted %0d",
                                      out_mon.has_char, want.has_char));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_mon.status, want.status));
          if (out_mon.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0d, predicted %0d",
                                      out_mon.run_last, want.run_last));
          if (out_mon.expr_end !== want.expr_end)
            report_mismatch($sformatf("expr_end %0d, predicted %0d",
                                      out_mon.expr_end, want.expr_end));
        end
      end
    end
    pending <= awaited_postfix.size();
  end

endmodule

// ===== tb/sv/tb_infix_to_postfix_converter_unit.sv =====
// Testbench top for the infix-to-postfix converter: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_unit;
  import i2p_pkg::*;

  localparam int ITEM_GOAL    = 410;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * (STACK_DEPTH + 8);

  typedef logic [CHAR_W-1:0] char_q_t[$];

  logic clk;
  logic rst;
  int   sender_idle_pct;
  int   sink_stall_pct;
  int   items_sent;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;

  i2p_in_if  in_chan ();
  i2p_out_if out_chan ();

  infix_to_postfix_converter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  i2p_postfix_checker u_postfix_check (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[infix_to_postfix_converter_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] rand_letter();
    if ($urandom_range(1)) return CHAR_W'($urandom_range(CH_LO_A, CH_LO_Z));
    return CHAR_W'($urandom_range(CH_UP_A, CH_UP_Z));
  endfunction

  // Mostly the five real operators, now and then some other non-letter byte.
  function automatic logic [CHAR_W-1:0] rand_operator();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(11))
      0, 1:    c = CH_PLUS;
      2, 3:    c = CH_MINUS;
      4, 5:    c = CH_STAR;
      6, 7:    c = CH_SLASH;
      8, 9:    c = CH_CARET;
      default: begin
        do c = CHAR_W'($urandom_range(255));
        while (((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
               c == CH_LPAREN || c == CH_RPAREN);
      end
    endcase
    return c;
  endfunction

  // Balanced expression: terms joined by operators, with random nesting.
  function automatic char_q_t gen_balanced();
    char_q_t toks;
    int      terms;
    int      opens;
    terms = $urandom_range(1, 6);
    opens = 0;
    for (int t = 0; t < terms; t++) begin
      while ($urandom_range(3) == 0 && opens < 4) begin
        toks.push_back(CH_LPAREN);
        opens++;
      end
      toks.push_back(rand_letter());
      while (opens > 0 && $urandom_range(2) == 0) begin
        toks.push_back(CH_RPAREN);
        opens--;
      end
      if (t < terms - 1) toks.push_back(rand_operator());
    end
    while (opens > 0) begin
      toks.push_back(CH_RPAREN);
      opens--;
    end
    return toks;
  endfunction

  // Deep nesting that fills the stack and often overflows it.
  function automatic char_q_t gen_deep();
    char_q_t toks;
    int      levels;
    levels = $urandom_range(10, 18);
    repeat (levels) begin
      toks.push_back(CH_LPAREN);
      if ($urandom_range(1)) begin
        toks.push_back(rand_letter());
        toks.push_back(rand_operator());
      end
    end
    toks.push_back(rand_letter());
    repeat ($urandom_range(0, levels)) toks.push_back(CH_RPAREN);
    return toks;
  endfunction

  // Balanced expression with one character turned into ')', one parenthesis added or one character dropped.
  function automatic char_q_t gen_broken();
    char_q_t toks;
    int      idx;
    toks = gen_balanced();
    idx  = $urandom_range(toks.size() - 1);
    case ($urandom_range(3))
      0: toks[idx] = CH_RPAREN;
      1: toks.insert(idx, CH_LPAREN);
      2: if (toks.size() > 1) toks.delete(idx);
      default: toks.insert(idx, CH_RPAREN);
    endcase
    return toks;
  endfunction

  function automatic char_q_t gen_noise();
    char_q_t toks;
    repeat ($urandom_range(1, 8)) toks.push_back(CHAR_W'($urandom_range(255)));
    return toks;
  endfunction

  // One input transaction, preceded by a random idle gap.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_char <= c;
    in_chan.in_last <= last;
    do @(posedge clk);
    while (!in_chan.ready);
  endtask

  // Send an expression, one input transaction per character.
  task automatic send_expr(input char_q_t toks);
    foreach (toks[i]) begin
      send_char(toks[i], i == toks.size() - 1);
      items_sent++;
    end
  endtask

  // Wait until every predicted result has come out.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk);
    while (pending != 0);
  endtask

  initial begin
    char_q_t toks;
    int      pick;
    rst              = 1'b1;
    in_chan.valid    = 1'b0;
    in_chan.in_char  = '0;
    in_chan.in_last  = 1'b0;
    out_chan.ready   = 1'b0;
    sender_idle_pct  = 0;
    sink_stall_pct   = 0;
    items_sent       = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single letter that is also the last character.
    toks.push_back(CH_LO_A);
    send_expr(toks);

    // Every operator and the letter boundaries A, Z and z in one balanced expression.
    toks.delete();
    toks.push_back(CH_LPAREN);
    toks.push_back(CH_UP_A);
    toks.push_back(CH_PLUS);
    toks.push_back(CH_LO_Z);
    toks.push_back(CH_RPAREN);
    toks.push_back(CH_STAR);
    toks.push_back(CH_UP_Z);
    toks.push_back(CH_CARET);
    toks.push_back(CH_LO_A + 8'd1);
    toks.push_back(CH_MINUS);
    toks.push_back(CH_LO_A + 8'd2);
    toks.push_back(CH_SLASH);
    toks.push_back(CH_LO_A + 8'd3);
    send_expr(toks);

    // Unmatched closing parenthesis, then characters that must be ignored.
    toks.delete();
    toks.push_back(CH_RPAREN);
    toks.push_back(CH_LO_A + 8'd16);
    toks.push_back(CH_PLUS);
    send_expr(toks);

    // Zero byte and all-ones byte as lowest-precedence operators, '(' left at the end.
    toks.delete();
    toks.push_back(8'h00);
    toks.push_back(8'hFF);
    toks.push_back(CH_LPAREN);
    send_expr(toks);

    // Characters just outside the letter ranges.
    toks.delete();
    toks.push_back(CH_UP_A - 8'd1);
    toks.push_back(CH_UP_Z + 8'd1);
    toks.push_back(CH_LO_A - 8'd1);
    toks.push_back(CH_LO_Z + 8'd1);
    send_expr(toks);

    // Empty parentheses: the last character emits nothing but the end marker.
    toks.delete();
    toks.push_back(CH_LPAREN);
    toks.push_back(CH_RPAREN);
    send_expr(toks);

    // Random phases, each started from a fully drained converter.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          sender_idle_pct <= 0;
          sink_stall_pct  <= 0;
        end
        1: begin
          sender_idle_pct <= 65;
          sink_stall_pct  <= 0;
        end
        2: begin
          sender_idle_pct <= 0;
          sink_stall_pct  <= 65;
        end
        default: begin
          sender_idle_pct <= 19;
          sink_stall_pct  <= 19;
        end
      endcase
      while (items_sent < ITEM_GOAL * (phase + 1) / 4) begin
        pick = $urandom_range(99);
        if (pick < 60) toks = gen_balanced();
        else if (pick < 70) toks = gen_deep();
        else if (pick < 85) toks = gen_broken();
        else toks = gen_noise();
        send_expr(toks);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[infix_to_postfix_converter_unit] OK");
    end else begin
      $display("[infix_to_postfix_converter_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/i2p_pkg.sv
rtl/core/i2p_if.sv
rtl/core/i2p_ram.sv
rtl/core/infix_to_postfix_converter_unit.sv
rtl/core/i2p_checker.sv
tb/sv/i2p_postfix_checker.sv
tb/sv/tb_infix_to_postfix_converter_unit.sv
